### design/rotation_matrix_to_euler_angles_unit_macros.svh
// Assertion macros for the rotation matrix to Euler angles unit.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define RME_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rme assertion failed");
// Checked on every clock edge, reset included.
`define RME_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rme assertion failed");
`else
`define RME_ASSERT(lbl, prop)
`define RME_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### design/rme_pkg.sv
// Shared constants for the rotation matrix to Euler angles unit.
package rme_pkg;
  localparam int ZW = 34;
  localparam int OUT_W = 16;
  localparam int PRESCALE = 16;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd843314857;
  localparam logic signed [ZW-ZW/2-1:0] OUT_PI = 17'sd25736;
  localparam logic signed [ZW-1:0] ATAN_TABLE [32] = '{
    34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762579,
    34'sd33510843, 34'sd16771758, 34'sd8387925, 34'sd4194219,
    34'sd2097141, 34'sd1048575, 34'sd524288, 34'sd262144,
    34'sd131072, 34'sd65536, 34'sd32768, 34'sd16384,
    34'sd8192, 34'sd4096, 34'sd2048, 34'sd1024,
    34'sd512, 34'sd256, 34'sd128, 34'sd64,
    34'sd32, 34'sd16, 34'sd8, 34'sd4,
    34'sd2, 34'sd1, 34'sd0, 34'sd0
  };
endpackage

### design/rotation_matrix_to_euler_angles_unit.sv
// Top level of the rotation matrix to Euler angles unit.
// The unit takes one matrix per clock and never raises busy. Each result
// appears on done after these registered stages, in order: a multiply
// stage, a clamp stage, one square root stage per result bit, an argument
// stage, and three parallel CORDIC lanes with one stage per iteration plus
// pre-rotation and rounding. The receiver cannot stall; done is a one-cycle
// strobe.
module rotation_matrix_to_euler_angles_unit #(
  parameter int CORDIC_STEPS = 16,
  parameter int INPUT_FRACTION_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] fwd_x,
  input  logic signed [15:0] fwd_y,
  input  logic signed [15:0] fwd_z,
  input  logic signed [15:0] right_x,
  input  logic signed [15:0] right_y,
  input  logic signed [15:0] right_z,
  input  logic signed [15:0] up_y,
  output logic               done,
  output logic signed [15:0] angle_x,
  output logic signed [15:0] angle_y,
  output logic signed [15:0] angle_z
);
  import rme_pkg::*;
  `include "rotation_matrix_to_euler_angles_unit_macros.svh"

  localparam int F = INPUT_FRACTION_BITS;
  localparam int CW = ((2 * F + 1 > 32) ? 2 * F + 1 : 32) + 1;
  localparam int IW = ((F + 2 > 17) ? F + 2 : 17) + 1;
  localparam int SW = 7 * 16;
  localparam int LAT = F + CORDIC_STEPS + 7;

  logic [LAT-1:0] vld;

  logic [31:0] sq;
  logic [SW-1:0] a_side, b_side, s_side;
  logic [2*F:0] diff;
  logic [CW-1:0] one_c, sq_c;
  logic [F+1:0] r;

  logic signed [15:0] sfx, sfy, sfz, srx, sry, srz, suy;
  logic signed [IW-1:0] rp, rn;
  logic signed [IW-1:0] py, px, yy, yx, ry_a, rx_a;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end
  assign done = vld[LAT-1];

  // Square of forward y, exact.
  always_ff @(posedge clk) begin
    sq <= 32'(fwd_y * fwd_y);
    a_side <= {fwd_x, fwd_y, fwd_z, right_x, right_y, right_z, up_y};
  end

  always_comb begin
    one_c = CW'(1) << (2 * F);
    sq_c = CW'(sq);
  end

  always_ff @(posedge clk) begin
    diff <= (sq_c >= one_c) ? '0 : (2*F+1)'(one_c - sq_c);
    b_side <= a_side;
  end

  rme_isqrt #(.F(F), .SW(SW)) u_isqrt (
    .clk(clk), .v_in(diff), .side_in(b_side), .r_out(r), .side_out(s_side)
  );

  always_comb begin
    {sfx, sfy, sfz, srx, sry, srz, suy} = s_side;
    rp = IW'(signed'({1'b0, r}));
    rn = -rp;
  end

  // atan2 arguments of the three angles.
  always_ff @(posedge clk) begin
    py <= IW'(sfy);
    if (sfz == '0) begin
      px <= (sry < 0) ? rp : rn;
      yy <= IW'(srz);
      yx <= IW'(srx);
      ry_a <= '0;
      rx_a <= '0;
    end else if (sfz < 0) begin
      px <= rn;
      yy <= IW'(sfx);
      yx <= -IW'(sfz);
      ry_a <= IW'(sry);
      rx_a <= -IW'(suy);
    end else begin
      px <= rp;
      yy <= -IW'(sfx);
      yx <= IW'(sfz);
      ry_a <= -IW'(sry);
      rx_a <= IW'(suy);
    end
  end

  rme_cordic #(.IW(IW), .STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .y_in(py), .x_in(px), .angle(angle_x)
  );
  rme_cordic #(.IW(IW), .STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .y_in(yy), .x_in(yx), .angle(angle_y)
  );
  rme_cordic #(.IW(IW), .STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .y_in(ry_a), .x_in(rx_a), .angle(angle_z)
  );

  `RME_ASSERT(a_done_from_start, done |-> $past(start, LAT))
  `RME_ASSERT(a_roll_zero, (done && $past(fwd_z, LAT) == 16'sd0) |-> angle_z == 16'sd0)
  `RME_ASSERT_ALWAYS(a_pitch_range, done |-> (angle_x >= -16'sd25736 && angle_x <= 16'sd25736))
endmodule

### design/rme_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module rme_isqrt #(
  parameter int F = 14,
  parameter int SW = 112
) (
  input  logic            clk,
  input  logic [2*F:0]    v_in,
  input  logic [SW-1:0]   side_in,
  output logic [F+1:0]    r_out,
  output logic [SW-1:0]   side_out
);
  localparam int N = F + 2;
  localparam int R2W = 2 * F + 5;

  logic [F+1:0]   res  [N+1];
  logic [R2W-1:0] res2 [N+1];
  logic [2*F:0]   v    [N+1];
  logic [SW-1:0]  side [N+1];

  assign res[0] = '0;
  assign res2[0] = '0;
  assign v[0] = v_in;
  assign side[0] = side_in;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = F + 1 - k;
    logic [F+1:0]   cand;
    logic [R2W-1:0] cand2;
    logic           take;
    always_comb begin
      cand = res[k] | ((F+2)'(1) << B);
      // (res + 2^B)^2 built from the running square.
      cand2 = res2[k] + (R2W'(res[k]) << (B + 1)) + (R2W'(1) << (2 * B));
      take = cand2 <= R2W'(v[k]);
    end
    always_ff @(posedge clk) begin
      res[k+1] <= take ? cand : res[k];
      res2[k+1] <= take ? cand2 : res2[k];
      v[k+1] <= v[k];
      side[k+1] <= side[k];
    end
  end

  assign r_out = res[N];
  assign side_out = side[N];
endmodule

### design/rme_cordic.sv
// Pipelined vectoring CORDIC giving the negated, rounded atan2 in Q3.13.
module rme_cordic #(
  parameter int IW = 18,
  parameter int STEPS = 16
) (
  input  logic                         clk,
  input  logic signed [IW-1:0]         y_in,
  input  logic signed [IW-1:0]         x_in,
  output logic signed [rme_pkg::OUT_W-1:0] angle
);
  import rme_pkg::*;
  localparam int XW = IW + PRESCALE + 3;
  localparam int RW = ZW - 16;

  logic signed [XW-1:0] x [STEPS+1];
  logic signed [XW-1:0] y [STEPS+1];
  logic signed [ZW-1:0] z [STEPS+1];
  logic                 zero [STEPS+1];

  logic signed [XW-1:0] xp, yp;
  logic signed [RW-1:0] zr, zs;

  // Prescale and rotate the left half plane into the right one.
  always_comb begin
    xp = XW'(x_in) <<< PRESCALE;
    yp = XW'(y_in) <<< PRESCALE;
  end

  always_ff @(posedge clk) begin
    zero[0] <= (x_in == '0) && (y_in == '0);
    if (xp < 0) begin
      if (yp >= 0) begin
        x[0] <= yp;
        y[0] <= -xp;
        z[0] <= ANG_HALF_PI;
      end else begin
        x[0] <= -yp;
        y[0] <= xp;
        z[0] <= -ANG_HALF_PI;
      end
    end else begin
      x[0] <= xp;
      y[0] <= yp;
      z[0] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [XW-1:0] xs, ys;
    always_comb begin
      xs = x[i] >>> i;
      ys = y[i] >>> i;
    end
    always_ff @(posedge clk) begin
      zero[i+1] <= zero[i];
      if (y[i] > 0) begin
        x[i+1] <= x[i] + ys;
        y[i+1] <= y[i] - xs;
        z[i+1] <= z[i] + ATAN_TABLE[i];
      end else begin
        x[i+1] <= x[i] - ys;
        y[i+1] <= y[i] + xs;
        z[i+1] <= z[i] - ATAN_TABLE[i];
      end
    end
  end

  always_comb begin
    zr = RW'((z[STEPS] + (ZW'(1) <<< 15)) >>> 16);
    if (zero[STEPS]) begin
      zs = '0;
    end else if (zr > RW'(OUT_PI)) begin
      zs = RW'(OUT_PI);
    end else if (zr < -RW'(OUT_PI)) begin
      zs = -RW'(OUT_PI);
    end else begin
      zs = zr;
    end
  end

  always_ff @(posedge clk) begin
    angle <= OUT_W'(-zs);
  end
endmodule

### dv/testbench.sv
// Self-checking testbench for the rotation matrix to Euler angles unit.
`timescale 1ns / 1ps

module testbench;
  import rme_pkg::*;

  typedef struct packed {
    logic signed [15:0] fx, fy, fz, rx, ry, rz, uy;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] pitch, yaw, roll;
  } angles_t;

  localparam int STEPS = 16;
  localparam int FRAC = 14;
  localparam int LATENCY = FRAC + STEPS + 7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] fwd_x = '0, fwd_y = '0, fwd_z = '0;
  logic signed [15:0] right_x = '0, right_y = '0, right_z = '0, up_y = '0;
  logic done;
  logic signed [15:0] angle_x, angle_y, angle_z;

  angles_t expected_angles[$];
  int errors = 0;

  rotation_matrix_to_euler_angles_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
    .right_x(right_x), .right_y(right_y), .right_z(right_z), .up_y(up_y),
    .done(done), .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  // Arithmetic shift on a 64-bit value is a floor division by a power of two.
  function automatic longint vector_angle(longint ay, longint ax);
    longint vx, vy, acc, tmp, sx, sy;
    if (ax == 0 && ay == 0) return 0;
    vx = ax <<< PRESCALE;
    vy = ay <<< PRESCALE;
    acc = 0;
    if (vx < 0) begin
      tmp = vx;
      if (vy >= 0) begin
        vx = vy; vy = -tmp; acc = ANG_HALF_PI;
      end else begin
        vx = -vy; vy = tmp; acc = -longint'(ANG_HALF_PI);
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy > 0) begin
        vx = vx + sy; vy = vy - sx; acc += ATAN_TABLE[i];
      end else begin
        vx = vx - sy; vy = vy + sx; acc -= ATAN_TABLE[i];
      end
    end
    acc = (acc + (64'sd1 <<< 15)) >>> 16;
    if (acc > 25736) acc = 25736;
    if (acc < -25736) acc = -25736;
    return -acc;
  endfunction

  function automatic longint cos_term(longint fy);
    longint one, sq, diff, res, cand;
    one = 64'sd1 <<< (2 * FRAC);
    sq = fy * fy;
    diff = (sq >= one) ? 0 : one - sq;
    res = 0;
    for (int b = FRAC + 1; b >= 0; b--) begin
      cand = res | (64'sd1 <<< b);
      if (cand * cand <= diff) res = cand;
    end
    return res;
  endfunction

  function automatic angles_t euler_angles(matrix_t m);
    angles_t a;
    longint r, s;
    r = cos_term(m.fy);
    if (m.fz == 0) begin
      a.pitch = 16'(vector_angle(m.fy, (m.ry < 0) ? r : -r));
      a.yaw = 16'(vector_angle(m.rz, m.rx));
      a.roll = '0;
    end else begin
      s = (m.fz < 0) ? -1 : 1;
      a.pitch = 16'(vector_angle(m.fy, r * s));
      a.yaw = 16'(vector_angle(-longint'(m.fx) * s, longint'(m.fz) * s));
      a.roll = 16'(vector_angle(-longint'(m.ry) * s, longint'(m.uy) * s));
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    angles_t want;
    if (!rst && done) begin
      if (expected_angles.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        want = expected_angles.pop_front();
        if (angle_x !== want.pitch) report_mismatch("angle_x", angle_x, want.pitch);
        if (angle_y !== want.yaw) report_mismatch("angle_y", angle_y, want.yaw);
        if (angle_z !== want.roll) report_mismatch("angle_z", angle_z, want.roll);
      end
    end
  end

  int burst_left = 0;

  // One transaction; bursts of back-to-back items are separated by random gaps.
  task automatic send_matrix(matrix_t m);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    {fwd_x, fwd_y, fwd_z, right_x, right_y, right_z, up_y} <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_angles.push_back(euler_angles(m));
  endtask

  task automatic drain;
    start <= 1'b0;
    burst_left = 0;
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    matrix_t m;
    send_matrix('0);
    m = '0; m.fx = 16'sh8000; m.fy = 16'sh8000; m.fz = 16'sh8000;
    m.rx = 16'sh8000; m.ry = 16'sh8000; m.rz = 16'sh8000; m.uy = 16'sh8000;
    send_matrix(m);
    m = {7{16'sh7fff}};
    send_matrix(m);
    // Identity-like orientation and forward z zero with both signs of right y.
    m = '0; m.fz = 16'sd16384; m.uy = 16'sd16384; m.rx = 16'sd16384;
    send_matrix(m);
    m = '0; m.fy = 16'sd8000; m.ry = -16'sd5; m.rx = -16'sd100;
    send_matrix(m);
    m = '0; m.fy = -16'sd8000; m.ry = 16'sd5; m.rz = 16'sd300;
    send_matrix(m);
    // Angle of pi: y zero with x negative.
    m = '0; m.rx = -16'sd1000;
    send_matrix(m);
    m = '0; m.fz = -16'sd16384; m.uy = 16'sd16384;
    send_matrix(m);
    // Forward y beyond unit length clamps the root to zero.
    m = '0; m.fy = 16'sd20000; m.fz = 16'sd3;
    send_matrix(m);
    m = '0; m.fy = 16'sd16384; m.fz = -16'sd1; m.ry = 16'sd1;
    send_matrix(m);
    drain();
  endtask

  task automatic test_random(int count);
    matrix_t m;
    for (int n = 0; n < count; n++) begin
      m = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
           rand_word(), rand_word()};
      if ($urandom_range(0, 5) == 0) m.fz = '0;
      send_matrix(m);
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(650);
    test_random(650);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
